@@ sv/dead_slot_membership_scan_top_macros.svh @@
// Assertion macros for the dead slot membership scan block.
// Taken in by the top level; needs nothing else.
`ifndef DEAD_SLOT_MEMBERSHIP_SCAN_TOP_MACROS_SVH
`define DEAD_SLOT_MEMBERSHIP_SCAN_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Condition must hold in the same cycle as the trigger.
`define DSMS_ASSERT_SAME(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (cond)) \
        else $error("dsms: same-cycle check failed");
// Condition must hold in the cycle after the trigger.
`define DSMS_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
        else $error("dsms: next-cycle check failed");
`else
`define DSMS_ASSERT_SAME(label, clk, rst_n, trig, cond)
`define DSMS_ASSERT_NEXT(label, clk, rst_n, trig, cond)
`endif

`endif

@@ sv/dsms_pkg.sv @@
// Shared types and constants for the dead slot membership scan block.
// Used by the interfaces, the controller, the datapath and the top level.
package dsms_pkg;

    // Default sizes of the live store and of the slot table.
    localparam int LIVE_DEPTH_DEF = 128;
    localparam int SLOT_DEPTH_DEF = 1024;

    // Fixed field widths of the words on the channels.
    localparam int KEY_W       = 64;
    localparam int MODE_W      = 2;
    localparam int SLOT_OUT_W  = 10;
    localparam int COUNT_OUT_W = 11;

    // Key value that marks an empty slot, and the tombstone after reset.
    localparam logic [KEY_W-1:0] EMPTY_KEY  = '0;
    localparam logic [KEY_W-1:0] TOMB_RESET = '1;

    // Item modes.
    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_SCAN   = 2'd2,
        MODE_FINISH = 2'd3
    } t_mode;

    // Result kinds.
    localparam logic KIND_DEAD  = 1'b0;
    localparam logic KIND_TOTAL = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;          // an input word is accepted this cycle
        logic clear;         // start a new batch
        logic add;           // append a live key
        logic scan;          // count one table slot
        logic search_start;  // rewind the live store read pointer
        logic search;        // step the live store search
        logic dead_inc;      // count one dead slot
        logic load_kind;     // latch the kind of the pending result
        logic kind;          // kind to latch
        logic emit;          // load the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic slot_full;   // slot counter has reached the table size
        logic key_occ;     // incoming key is neither empty nor tombstone
        logic live_empty;  // no live keys stored
        logic hit;         // search found the key
        logic miss;        // search went through every entry without a match
        logic out_free;    // output register can take a word this cycle
    } t_status;

endpackage

@@ sv/dsms_if.sv @@
// Valid/ready channel interfaces for the input and result words.
// Depends on dsms_pkg for the field widths.
interface dsms_in_if import dsms_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [KEY_W-1:0]  key_value;

    modport source (output valid, output mode, output key_value, input ready);
    modport sink   (input valid, input mode, input key_value, output ready);
endinterface

interface dsms_out_if import dsms_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    result_kind;
    logic [SLOT_OUT_W-1:0]   slot_index;
    logic [COUNT_OUT_W-1:0]  occupied_count;
    logic [COUNT_OUT_W-1:0]  dead_slots;
    logic                    overflow_flag;

    modport source (output valid, output result_kind, output slot_index,
                    output occupied_count, output dead_slots, output overflow_flag,
                    input ready);
    modport sink   (input valid, input result_kind, input slot_index,
                    input occupied_count, input dead_slots, input overflow_flag,
                    output ready);
endinterface

@@ sv/dsms_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module dsms_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/dsms_ctrl.sv @@
// Controller state machine: decodes accepted words and sequences search and result.
// Depends on dsms_pkg for the state, mode, command and status types.
module dsms_ctrl import dsms_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [MODE_W-1:0] i_mode,
    input  t_status           i_status,
    output logic              o_in_ready,
    output t_cmd              o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    unique case (t_mode'(i_mode))
                        MODE_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        MODE_ADD: begin
                            o_cmd.add = 1'b1;
                        end
                        MODE_SCAN: begin
                            o_cmd.scan = 1'b1;
                            if (!i_status.slot_full && i_status.key_occ) begin
                                if (i_status.live_empty) begin
                                    o_cmd.dead_inc  = 1'b1;
                                    o_cmd.load_kind = 1'b1;
                                    o_cmd.kind      = KIND_DEAD;
                                    n_state         = S_EMIT;
                                end else begin
                                    o_cmd.search_start = 1'b1;
                                    n_state            = S_SEARCH;
                                end
                            end
                        end
                        MODE_FINISH: begin
                            o_cmd.load_kind = 1'b1;
                            o_cmd.kind      = KIND_TOTAL;
                            n_state         = S_EMIT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_status.hit) begin
                    n_state = S_IDLE;
                end else if (i_status.miss) begin
                    o_cmd.dead_inc  = 1'b1;
                    o_cmd.load_kind = 1'b1;
                    o_cmd.kind      = KIND_DEAD;
                    n_state         = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/dsms_dp.sv @@
// Datapath: tombstone register, batch counters, live store search and output register.
// Depends on dsms_pkg and on dsms_ram for the live store.
module dsms_dp import dsms_pkg::*; #(
    parameter int LIVE_DEPTH = LIVE_DEPTH_DEF,
    parameter int SLOT_DEPTH = SLOT_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic signed [KEY_W-1:0] i_cfg_wr_data,
    input  logic signed [KEY_W-1:0] i_key_value,
    input  t_cmd                    i_cmd,
    input  logic                    i_out_ready,
    output t_status                 o_status,
    output logic                    o_out_valid,
    output logic                    o_result_kind,
    output logic [SLOT_OUT_W-1:0]   o_slot_index,
    output logic [COUNT_OUT_W-1:0]  o_occupied_count,
    output logic [COUNT_OUT_W-1:0]  o_dead_slots,
    output logic                    o_overflow_flag
);

    localparam int AW = (LIVE_DEPTH > 1) ? $clog2(LIVE_DEPTH) : 1;
    localparam int FW = $clog2(LIVE_DEPTH + 1);
    localparam int SW = $clog2(SLOT_DEPTH);
    localparam int CW = $clog2(SLOT_DEPTH + 1);

    logic [KEY_W-1:0] r_tomb;
    logic [KEY_W-1:0] r_key;
    logic [FW-1:0]    r_fill;
    logic [FW-1:0]    r_rd_addr;
    logic             r_rd_pend;
    logic [CW-1:0]    r_slot_cnt;
    logic [CW-1:0]    r_occ;
    logic [CW-1:0]    r_dead;
    logic             r_flag;
    logic [SW-1:0]    r_slot;
    logic             r_kind;
    logic             r_out_valid;
    logic             r_out_kind;
    logic [SLOT_OUT_W-1:0]  r_out_slot;
    logic [COUNT_OUT_W-1:0] r_out_occ;
    logic [COUNT_OUT_W-1:0] r_out_dead;
    logic             r_out_flag;

    logic [KEY_W-1:0] key_in;
    logic [KEY_W-1:0] ram_q;
    logic             fill_room;
    logic             wr_en;
    logic             rd_en;
    logic             match;
    logic             scan_ok;
    logic [SW+SLOT_OUT_W-1:0] slot_ext;
    logic [CW+COUNT_OUT_W-1:0] occ_ext;
    logic [CW+COUNT_OUT_W-1:0] dead_ext;

    assign key_in    = $unsigned(i_key_value);
    assign fill_room = (r_fill < FW'(LIVE_DEPTH));
    assign wr_en     = i_cmd.add && fill_room;
    assign match     = r_rd_pend && (ram_q == r_key);
    assign rd_en     = i_cmd.search && (r_rd_addr < r_fill) && !match;
    assign scan_ok   = i_cmd.scan && !o_status.slot_full;

    // Status toward the controller.
    assign o_status.slot_full  = (r_slot_cnt >= CW'(SLOT_DEPTH));
    assign o_status.key_occ    = (key_in != EMPTY_KEY) && (key_in != r_tomb);
    assign o_status.live_empty = (r_fill == '0);
    assign o_status.hit        = match;
    assign o_status.miss       = r_rd_pend && !match && (r_rd_addr == r_fill);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    // Live key store.
    dsms_ram #(
        .WIDTH (KEY_W),
        .DEPTH (LIVE_DEPTH)
    ) u_live_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill[AW-1:0]),
        .i_wr_data (key_in),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_addr[AW-1:0]),
        .o_rd_data (ram_q)
    );

    // Tombstone register, written from the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tomb <= TOMB_RESET;
        end else if (i_cfg_wr_en) begin
            r_tomb <= $unsigned(i_cfg_wr_data);
        end
    end

    // Batch counters and the sticky capacity flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_slot_cnt <= '0;
            r_occ      <= '0;
            r_dead     <= '0;
            r_flag     <= 1'b0;
        end else if (i_cmd.clear) begin
            r_fill     <= '0;
            r_slot_cnt <= '0;
            r_occ      <= '0;
            r_dead     <= '0;
            r_flag     <= 1'b0;
        end else begin
            if (wr_en) begin
                r_fill <= r_fill + FW'(1);
            end
            if ((i_cmd.add && !fill_room) || (i_cmd.scan && o_status.slot_full)) begin
                r_flag <= 1'b1;
            end
            if (scan_ok) begin
                r_slot_cnt <= r_slot_cnt + CW'(1);
                if (o_status.key_occ) begin
                    r_occ <= r_occ + CW'(1);
                end
            end
            if (i_cmd.dead_inc) begin
                r_dead <= r_dead + CW'(1);
            end
        end
    end

    // Search pointer and read-data valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_addr <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= rd_en;
            if (i_cmd.search_start) begin
                r_rd_addr <= '0;
            end else if (rd_en) begin
                r_rd_addr <= r_rd_addr + FW'(1);
            end
        end
    end

    // Per-item payload: search key, slot number and pending result kind.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= key_in;
        end
        if (scan_ok) begin
            r_slot <= r_slot_cnt[SW-1:0];
        end
        if (i_cmd.load_kind) begin
            r_kind <= i_cmd.kind;
        end
    end

    assign slot_ext = {{SLOT_OUT_W{1'b0}}, r_slot};
    assign occ_ext  = {{COUNT_OUT_W{1'b0}}, r_occ};
    assign dead_ext = {{COUNT_OUT_W{1'b0}}, r_dead};

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_kind <= r_kind;
            r_out_slot <= (r_kind == KIND_TOTAL) ? '0 : slot_ext[SLOT_OUT_W-1:0];
            r_out_occ  <= occ_ext[COUNT_OUT_W-1:0];
            r_out_dead <= dead_ext[COUNT_OUT_W-1:0];
            r_out_flag <= r_flag;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_kind    = r_out_kind;
    assign o_slot_index     = r_out_slot;
    assign o_occupied_count = r_out_occ;
    assign o_dead_slots     = r_out_dead;
    assign o_overflow_flag  = r_out_flag;

endmodule

@@ sv/dead_slot_membership_scan_top.sv @@
// Dead slot membership scan: sweeps a key table against a set of live keys.
// Input words arrive on a valid/ready channel with a mode and a 64-bit key:
// clear starts a batch, add stores a live key, scan presents one table slot,
// finish asks for the batch totals. Result words leave on a second channel:
// a dead slot report (slot index and running totals) or the batch totals.
// The tombstone key is set through a write enable and data port.
// Clear, add and a scan of an empty or tombstone key, or one past the table
// end, leave the input ready for the next word. An occupied key is searched
// for in the live store, one entry per cycle through the store's single read
// port: a hit frees the input, a miss after the last stored entry loads a dead
// report into the output register, and an empty store gives the dead report
// without a search. Finish loads its batch totals into the output register.
// A result waits in the output register while the receiver stalls; the block
// keeps taking words that give no result, and a word that gives a result
// holds off the next word until that result is loaded into a free register.
// Reset sets the tombstone to all ones and clears the batch counters; the
// live store needs no clearing since only entries below the fill are read.
// Depends on dsms_pkg, dsms_if, dsms_ram, dsms_ctrl, dsms_dp and the macro header.
`include "dead_slot_membership_scan_top_macros.svh"

module dead_slot_membership_scan_top import dsms_pkg::*; #(
    parameter int LIVE_DEPTH = LIVE_DEPTH_DEF,
    parameter int SLOT_DEPTH = SLOT_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic signed [KEY_W-1:0] i_cfg_wr_data,
    dsms_in_if.sink                 i_in_ch,
    dsms_out_if.source              o_out_ch
);

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    assign i_in_ch.ready = in_ready;

    // Controller.
    dsms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .i_mode     (i_in_ch.mode),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // Datapath.
    dsms_dp #(
        .LIVE_DEPTH (LIVE_DEPTH),
        .SLOT_DEPTH (SLOT_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_key_value      (i_in_ch.key_value),
        .i_cmd            (cmd),
        .i_out_ready      (o_out_ch.ready),
        .o_status         (status),
        .o_out_valid      (o_out_ch.valid),
        .o_result_kind    (o_out_ch.result_kind),
        .o_slot_index     (o_out_ch.slot_index),
        .o_occupied_count (o_out_ch.occupied_count),
        .o_dead_slots     (o_out_ch.dead_slots),
        .o_overflow_flag  (o_out_ch.overflow_flag)
    );

    // A result is only loaded when the output register can take it.
    `DSMS_ASSERT_SAME(a_emit_free, i_clk, i_rst_n, cmd.emit, status.out_free)
    // No input word is taken while the live store is being searched.
    `DSMS_ASSERT_SAME(a_search_blocks, i_clk, i_rst_n, cmd.search, !in_ready)
    // A loaded result shows up as valid in the next cycle.
    `DSMS_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, cmd.emit, o_out_ch.valid)
    // Totals words carry a zero slot index.
    `DSMS_ASSERT_SAME(a_total_slot, i_clk, i_rst_n,
        o_out_ch.valid && (o_out_ch.result_kind == KIND_TOTAL), o_out_ch.slot_index == '0)

endmodule
